[rtl/scfb_pkg.sv]
// Shared types, constants and CRC helper for the CRC frame builder.
`timescale 1ns / 1ps

package scfb_pkg;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   localparam logic [1:0] CSR_CRC_SEED   = 2'd0;
   localparam logic [1:0] CSR_MIN_LENGTH = 2'd1;
   localparam logic [1:0] CSR_MAX_LENGTH = 2'd2;

   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
   localparam logic [7:0]  SYNC_HI_BYTE  = 8'h93;
   localparam logic [7:0]  SYNC_LO_BYTE  = 8'hC7;
   localparam logic [7:0]  ZERO_BYTE     = 8'h00;
   localparam logic [7:0]  FILL_BYTE     = 8'hFF;
   localparam logic [7:0]  MARK_BYTE     = 8'hFE;

   typedef struct packed {
      logic       func;
      logic [7:0] frame_length;
      logic [7:0] frame_type;
      logic [7:0] sequence_number;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] wire_byte;
      logic       status;
      logic       frame_end;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_REJECT,
      CMD_START,
      CMD_DATA
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         last;
      logic [7:0]   value;
      logic [7:0]   frame_type;
      logic [7:0]   sequence_number;
   } cmd_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

[rtl/scfb_front.sv]
// Front end: accepts requests, tracks the open frame and issues commands.
`timescale 1ns / 1ps

module scfb_front
   import scfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic [7:0] min_length,
   input  logic [7:0] max_length,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic       in_frame_ff, in_frame_in;
   logic [7:0] left_ff, left_in;
   logic       accept;
   logic       bad_length;

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign bad_length = (req_data.frame_length < min_length) ||
                       (req_data.frame_length > max_length);

   always_comb begin
      q_push                = 1'b0;
      q_cmd.kind            = CMD_DATA;
      q_cmd.last            = 1'b0;
      q_cmd.value           = req_data.data_byte;
      q_cmd.frame_type      = req_data.frame_type;
      q_cmd.sequence_number = req_data.sequence_number;
      in_frame_in           = in_frame_ff;
      left_in               = left_ff;
      if (accept) begin
         if (req_data.func == FUNC_START) begin
            q_push      = 1'b1;
            q_cmd.kind  = bad_length ? CMD_REJECT : CMD_START;
            q_cmd.last  = (req_data.frame_length == 8'd0);
            q_cmd.value = req_data.frame_length;
            in_frame_in = !bad_length && (req_data.frame_length != 8'd0);
            left_in     = bad_length ? 8'd0 : req_data.frame_length;
         end else if (in_frame_ff) begin
            q_push      = 1'b1;
            q_cmd.kind  = CMD_DATA;
            q_cmd.last  = (left_ff == 8'd1);
            left_in     = left_ff - 8'd1;
            in_frame_in = (left_ff != 8'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         left_ff     <= 8'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         left_ff     <= left_in;
      end
   end

`ifndef SYNTHESIS
   a_open_frame_has_bytes: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (left_ff != 8'd0))
      else $error("open frame with no payload bytes left");
`endif

endmodule

[rtl/scfb_fifo.sv]
// Command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module scfb_fifo
   import scfb_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   assign full      = (count_ff == CW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");
`endif

endmodule

[rtl/scfb_back.sv]
// Byte sequencer: expands commands into frame bytes with CRC, padding and postamble.
`timescale 1ns / 1ps

module scfb_back
   import scfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] crc_seed,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_HEAD,
      S_TRAIL
   } state_type;

   localparam logic [3:0] STEP_PREAMBLE = 4'd1;
   localparam logic [3:0] STEP_SYNC_HI  = 4'd2;
   localparam logic [3:0] STEP_SYNC_LO  = 4'd3;
   localparam logic [3:0] STEP_LEN      = 4'd4;
   localparam logic [3:0] STEP_TYPE     = 4'd5;
   localparam logic [3:0] STEP_SEQ      = 4'd6;
   localparam logic [3:0] STEP_HEAD_END = 4'd7;
   localparam logic [3:0] STEP_CRC_HI   = 4'd0;
   localparam logic [3:0] STEP_CRC_LO   = 4'd1;

   state_type   state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] crc_ff, crc_in, crc_base;
   logic        par_ff, par_in, par_base;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  typ_ff, typ_in;
   logic [7:0]  seq_ff, seq_in;
   logic        last_ff, last_in;
   logic [1:0]  lb_ff, lb_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic        advance, emit, feed, counted;
   rsp_type     out_item;
   logic [2:0]  pad_count;
   logic [3:0]  mark_step, end_step;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign pad_count = 3'd4 - {1'b0, 2'(lb_ff + 2'd2)};
   assign mark_step = 4'd1 + {1'b0, pad_count};
   assign end_step  = 4'd5 + {1'b0, pad_count};

   always_comb begin
      emit      = 1'b0;
      feed      = 1'b0;
      counted   = 1'b0;
      q_pop     = 1'b0;
      out_item  = '{wire_byte: ZERO_BYTE, status: 1'b0, frame_end: 1'b0};
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      crc_base  = crc_ff;
      par_base  = par_ff;
      len_in    = len_ff;
      typ_in    = typ_ff;
      seq_in    = seq_ff;
      last_in   = last_ff;
      lb_in     = lb_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               emit  = 1'b1;
               q_pop = advance;
               unique case (q_cmd.kind)
                  CMD_REJECT: begin
                     out_item.status    = 1'b1;
                     out_item.frame_end = 1'b1;
                  end
                  CMD_START: begin
                     out_item.wire_byte = PREAMBLE_BYTE;
                     counted  = 1'b1;
                     par_base = 1'b0;
                     crc_base = crc_seed;
                     len_in   = q_cmd.value;
                     typ_in   = q_cmd.frame_type;
                     seq_in   = q_cmd.sequence_number;
                     last_in  = q_cmd.last;
                     lb_in    = q_cmd.value[1:0];
                     state_in = S_HEAD;
                     cnt_in   = STEP_PREAMBLE;
                  end
                  CMD_DATA: begin
                     out_item.wire_byte = q_cmd.value;
                     feed    = 1'b1;
                     counted = 1'b1;
                     if (q_cmd.last) begin
                        state_in = S_TRAIL;
                        cnt_in   = STEP_CRC_HI;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_HEAD: begin
            emit    = 1'b1;
            counted = 1'b1;
            cnt_in  = cnt_ff + 4'd1;
            case (cnt_ff)
               STEP_PREAMBLE: out_item.wire_byte = PREAMBLE_BYTE;
               STEP_SYNC_HI:  out_item.wire_byte = SYNC_HI_BYTE;
               STEP_SYNC_LO:  out_item.wire_byte = SYNC_LO_BYTE;
               STEP_LEN:      out_item.wire_byte = len_ff;
               STEP_TYPE:     out_item.wire_byte = typ_ff;
               STEP_SEQ:      out_item.wire_byte = seq_ff;
               default:       out_item.wire_byte = ZERO_BYTE;
            endcase
            feed = (cnt_ff >= STEP_LEN);
            if (cnt_ff == STEP_HEAD_END) begin
               state_in = last_ff ? S_TRAIL : S_IDLE;
               cnt_in   = STEP_CRC_HI;
            end
         end
         S_TRAIL: begin
            emit   = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == STEP_CRC_HI) begin
               out_item.wire_byte = crc_ff[15:8];
               counted = 1'b1;
            end else if (cnt_ff == STEP_CRC_LO) begin
               out_item.wire_byte = crc_ff[7:0];
               counted = 1'b1;
            end else if (cnt_ff == mark_step) begin
               out_item.wire_byte = par_ff ? MARK_BYTE : FILL_BYTE;
            end else begin
               out_item.wire_byte = FILL_BYTE;
            end
            if (cnt_ff == end_step) begin
               out_item.frame_end = 1'b1;
               state_in = S_IDLE;
               cnt_in   = 4'd0;
            end
         end
         default: ;
      endcase
      crc_in = feed ? crc_step(crc_base, out_item.wire_byte) : crc_base;
      par_in = counted ? (par_base ^ (^out_item.wire_byte)) : par_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= 16'd0;
         par_ff       <= 1'b0;
         last_ff      <= 1'b0;
         lb_ff        <= 2'd0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
         if (emit) begin
            rsp_data_ff <= out_item;
            state_ff    <= state_in;
            cnt_ff      <= cnt_in;
            crc_ff      <= crc_in;
            par_ff      <= par_in;
            len_ff      <= len_in;
            typ_ff      <= typ_in;
            seq_ff      <= seq_in;
            last_ff     <= last_in;
            lb_ff       <= lb_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_reject_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status) |->
         (rsp_data_ff.frame_end && rsp_data_ff.wire_byte == ZERO_BYTE))
      else $error("reject result malformed");
   a_head_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HEAD) |-> (cnt_ff >= STEP_PREAMBLE && cnt_ff <= STEP_HEAD_END))
      else $error("header step out of range");
`endif

endmodule

[rtl/sync_crc_frame_builder.sv]
// Usage notes:
// Request channel (req_valid, req_stall, req_data) takes start requests
// (func 0: length, type, sequence) and payload requests (func 1: one byte).
// Result channel (rsp_valid, rsp_stall, rsp_data) delivers one frame byte per
// transfer: preamble AA AA, sync 93 C7, header LEN TYPE SEQ 00, payload,
// CRC16 high then low, 1 to 4 padding bytes, four FF postamble bytes.
// A start with a length outside [min_length, max_length] gives one reject
// result (byte 0, status 1, frame_end 1). Payload outside a frame is dropped.
// The first result of a request passes through the command queue and the
// output register. A start request expands to 8 bytes and the last payload
// request to up to 10 more, one byte per cycle out of the sequencer unless
// rsp_stall holds it. The command queue (QUEUE_DEPTH entries) absorbs requests
// while these bursts go out; req_stall is high only while the queue is full.
// rsp_stall freezes the output register and sequencer; requests continue
// to be taken until the queue fills. Synchronous reset empties the queue,
// drops any open frame and loads the register defaults: crc_seed FFFF,
// min_length 1, max_length 128. Write registers only while the block is idle.
`timescale 1ns / 1ps

module sync_crc_frame_builder
   import scfb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   logic [15:0] crc_seed_ff;
   logic [7:0]  min_length_ff;
   logic [7:0]  max_length_ff;

   logic    q_full, q_push, q_pop, q_valid;
   cmd_type push_cmd, pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_seed_ff   <= 16'hFFFF;
         min_length_ff <= 8'd1;
         max_length_ff <= 8'd128;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CRC_SEED:   crc_seed_ff   <= csr_write_data;
            CSR_MIN_LENGTH: min_length_ff <= csr_write_data[7:0];
            CSR_MAX_LENGTH: max_length_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   scfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .min_length (min_length_ff),
      .max_length (max_length_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   scfb_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (pop_cmd)
   );

   scfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .crc_seed  (crc_seed_ff),
      .q_valid   (q_valid),
      .q_cmd     (pop_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/sync_crc_frame_builder_test.sv]
// Self-checking testbench for the CRC frame builder: directed and random framing traffic.
`timescale 1ns / 1ps

module sync_crc_frame_builder_test;
   import scfb_pkg::*;

   localparam logic STATUS_FRAME  = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;
   localparam int   DRAIN_CYCLES  = 24;
   localparam int   LONG_HOLD_AT  = 150;
   localparam int   LONG_HOLD_LEN = 200;
   localparam int   LONG_HOLD_MIN_PENDING = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_CRC_SEED;
   logic [15:0] csr_write_data = '0;

   logic [15:0] cfg_crc_seed = 16'hFFFF;
   logic [7:0]  cfg_min_len = 8'd1;
   logic [7:0]  cfg_max_len = 8'd128;

   logic        tx_active = 1'b0;
   logic [7:0]  tx_remaining = '0;
   logic [1:0]  tx_len_low = '0;
   logic [15:0] tx_crc = '0;
   logic        tx_parity = 1'b0;

   req_type     pending_reqs[$];
   rsp_type     expected_bytes[$];
   int          failures = 0;
   bit          idling_on = 1'b1;
   int          req_gap_left = 0;
   int          stall_left = 0;
   int          long_hold_left = 0;
   bit          long_hold_done = 1'b0;
   int          bytes_checked = 0;

   sync_crc_frame_builder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** sync_crc_frame_builder: FAILED **");
      $finish;
   end

   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        msb;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         msb = c[15];
         c = {c[14:0], 1'b0};
         if (msb) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function automatic void expect_byte(input logic [7:0] b, input logic st, input logic fe);
      rsp_type r;
      r.wire_byte = b;
      r.status = st;
      r.frame_end = fe;
      expected_bytes.push_back(r);
   endfunction

   function automatic void expect_counted(input logic [7:0] b);
      tx_parity = tx_parity ^ (^b);
      expect_byte(b, STATUS_FRAME, 1'b0);
   endfunction

   function automatic void expect_trailer();
      int pad;
      expect_counted(tx_crc[15:8]);
      expect_counted(tx_crc[7:0]);
      pad = 4 - ((6 + int'(tx_len_low)) & 3);
      for (int i = 0; i < pad - 1; i++) expect_byte(FILL_BYTE, STATUS_FRAME, 1'b0);
      expect_byte(tx_parity ? MARK_BYTE : FILL_BYTE, STATUS_FRAME, 1'b0);
      for (int i = 0; i < 3; i++) expect_byte(FILL_BYTE, STATUS_FRAME, 1'b0);
      expect_byte(FILL_BYTE, STATUS_FRAME, 1'b1);
      tx_active = 1'b0;
      tx_remaining = '0;
   endfunction

   function automatic void predict_frame_bytes(input req_type r);
      logic [7:0] hdr[4];
      if (r.func == FUNC_START) begin
         tx_active = 1'b0;
         tx_remaining = '0;
         if (r.frame_length < cfg_min_len || r.frame_length > cfg_max_len) begin
            expect_byte(ZERO_BYTE, STATUS_REJECT, 1'b1);
         end else begin
            tx_parity = 1'b0;
            expect_counted(PREAMBLE_BYTE);
            expect_counted(PREAMBLE_BYTE);
            expect_counted(SYNC_HI_BYTE);
            expect_counted(SYNC_LO_BYTE);
            hdr[0] = r.frame_length;
            hdr[1] = r.frame_type;
            hdr[2] = r.sequence_number;
            hdr[3] = ZERO_BYTE;
            tx_crc = cfg_crc_seed;
            for (int i = 0; i < 4; i++) begin
               tx_crc = crc16_feed(tx_crc, hdr[i]);
               expect_counted(hdr[i]);
            end
            tx_len_low = r.frame_length[1:0];
            tx_remaining = r.frame_length;
            tx_active = 1'b1;
            if (tx_remaining == 0) expect_trailer();
         end
      end else if (tx_active && tx_remaining != 0) begin
         tx_crc = crc16_feed(tx_crc, r.data_byte);
         expect_counted(r.data_byte);
         tx_remaining = tx_remaining - 8'd1;
         if (tx_remaining == 0) expect_trailer();
      end
   endfunction

   function automatic req_type make_start(input logic [7:0] len, input logic [7:0] typ,
                                          input logic [7:0] seq);
      req_type r;
      r.func = FUNC_START;
      r.frame_length = len;
      r.frame_type = typ;
      r.sequence_number = seq;
      r.data_byte = 8'($urandom);
      return r;
   endfunction

   function automatic req_type make_payload(input logic [7:0] d);
      req_type r;
      r.func = FUNC_DATA;
      r.frame_length = 8'($urandom);
      r.frame_type = 8'($urandom);
      r.sequence_number = 8'($urandom);
      r.data_byte = d;
      return r;
   endfunction

   function automatic int pick_length();
      int lo;
      int hi;
      lo = cfg_min_len;
      hi = cfg_max_len;
      if (hi - lo > 12 && $urandom_range(19, 0) != 0) hi = lo + 8;
      return $urandom_range(hi, lo);
   endfunction

   function automatic int pick_bad_length();
      bit low_ok;
      bit high_ok;
      low_ok = cfg_min_len != 0;
      high_ok = cfg_max_len != 8'hFF;
      if (low_ok && (!high_ok || $urandom_range(1, 0) == 0))
         return $urandom_range(int'(cfg_min_len) - 1, 0);
      else if (high_ok)
         return $urandom_range(255, int'(cfg_max_len) + 1);
      return pick_length();
   endfunction

   task automatic queue_random_traffic(input int target);
      int made;
      int choice;
      int len;
      int cut;
      made = 0;
      while (made < target) begin
         choice = $urandom_range(99, 0);
         if (choice < 75 && cfg_min_len <= cfg_max_len) begin
            len = pick_length();
            cut = len;
            if (len > 0 && $urandom_range(9, 0) == 0) cut = $urandom_range(len - 1, 0);
            pending_reqs.push_back(make_start(8'(len), 8'($urandom), 8'($urandom)));
            for (int i = 0; i < cut; i++) pending_reqs.push_back(make_payload(8'($urandom)));
            made += 1 + cut;
         end else if (choice < 88) begin
            pending_reqs.push_back(make_start(8'(pick_bad_length()), 8'($urandom),
                                              8'($urandom)));
            made++;
         end else begin
            pending_reqs.push_back(make_payload(8'($urandom)));
            made++;
         end
      end
   endtask

   task automatic write_config(input logic [15:0] seed, input logic [7:0] lo,
                               input logic [7:0] hi);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CRC_SEED;
      csr_write_data <= seed;
      @(posedge clock);
      csr_index <= CSR_MIN_LENGTH;
      csr_write_data <= {8'h00, lo};
      @(posedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_write_data <= {8'h00, hi};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_crc_seed = seed;
      cfg_min_len = lo;
      cfg_max_len = hi;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_valid && !req_stall) predict_frame_bytes(req_data);
         if (!req_valid || !req_stall) begin
            if (req_gap_left == 0 && idling_on && $urandom_range(7, 0) == 0)
               req_gap_left = $urandom_range(17, 1);
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result: wire_byte %h status %b frame_end %b",
                      rsp_data.wire_byte, rsp_data.status, rsp_data.frame_end);
               failures++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.wire_byte !== want.wire_byte) begin
                  $error("wire_byte expected %h actual %h", want.wire_byte, rsp_data.wire_byte);
                  failures++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %b actual %b", want.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.frame_end !== want.frame_end) begin
                  $error("frame_end expected %b actual %b", want.frame_end, rsp_data.frame_end);
                  failures++;
               end
            end
            bytes_checked++;
         end
         // hold off once for a long stretch so the request queue fills
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_stall <= 1'b1;
         end else if (!long_hold_done && idling_on && bytes_checked >= LONG_HOLD_AT &&
                      pending_reqs.size() > LONG_HOLD_MIN_PENDING) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_LEN - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(7, 0) == 0) begin
            stall_left = $urandom_range(17, 1) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      pending_reqs.push_back(make_payload(8'h5A));
      pending_reqs.push_back(make_start(8'd0, 8'hFF, 8'hFF));
      pending_reqs.push_back(make_start(8'd129, 8'h00, 8'h00));
      pending_reqs.push_back(make_start(8'd255, 8'h3C, 8'hC3));
      pending_reqs.push_back(make_start(8'd1, 8'hFF, 8'hFF));
      pending_reqs.push_back(make_payload(8'hFF));
      pending_reqs.push_back(make_start(8'd2, 8'h00, 8'h00));
      pending_reqs.push_back(make_payload(8'h00));
      pending_reqs.push_back(make_payload(8'h00));
      pending_reqs.push_back(make_start(8'd3, 8'hA5, 8'h5A));
      pending_reqs.push_back(make_payload(8'h00));
      pending_reqs.push_back(make_payload(8'hFF));
      pending_reqs.push_back(make_payload(8'h80));
      pending_reqs.push_back(make_start(8'd4, 8'h01, 8'h80));
      for (int i = 1; i <= 4; i++) pending_reqs.push_back(make_payload(8'(i)));
      pending_reqs.push_back(make_start(8'd3, 8'h12, 8'h34));
      pending_reqs.push_back(make_payload(8'h77));
      pending_reqs.push_back(make_start(8'd1, 8'h56, 8'h78));
      pending_reqs.push_back(make_payload(8'h01));
      pending_reqs.push_back(make_payload(8'hC0));
      wait_idle();

      write_config(16'h0000, 8'd0, 8'd255);
      pending_reqs.push_back(make_start(8'd0, 8'h00, 8'h00));
      pending_reqs.push_back(make_start(8'd0, 8'hFF, 8'h80));
      pending_reqs.push_back(make_start(8'd2, 8'h0F, 8'hF0));
      pending_reqs.push_back(make_payload(8'h99));
      pending_reqs.push_back(make_start(8'd0, 8'h42, 8'h24));
      wait_idle();

      write_config(16'($urandom), 8'd200, 8'd100);
      pending_reqs.push_back(make_start(8'd150, 8'h11, 8'h22));
      pending_reqs.push_back(make_start(8'd0, 8'h33, 8'h44));
      pending_reqs.push_back(make_payload(8'h66));
      wait_idle();

      write_config(16'hFFFF, 8'd0, 8'd0);
      pending_reqs.push_back(make_start(8'd0, 8'h5A, 8'hA5));
      pending_reqs.push_back(make_start(8'd1, 8'hA5, 8'h5A));
      pending_reqs.push_back(make_payload(8'h3C));
      wait_idle();

      write_config(16'($urandom), 8'd1, 8'd16);
      queue_random_traffic(40);
      wait_idle();

      write_config(16'hFFFF, 8'd0, 8'd255);
      pending_reqs.push_back(make_start(8'd255, 8'($urandom), 8'($urandom)));
      for (int i = 0; i < 40; i++) pending_reqs.push_back(make_payload(8'($urandom)));
      queue_random_traffic(30);
      wait_idle();

      write_config(16'($urandom), 8'($urandom_range(6, 0)), 8'($urandom_range(26, 7)));
      queue_random_traffic(30);
      wait_idle();

      idling_on = 1'b0;
      write_config(16'($urandom), 8'd2, 8'd9);
      queue_random_traffic(50);
      wait_idle();

      if (failures == 0) begin
         $display("** sync_crc_frame_builder: PASSED **");
      end else begin
         $display("** sync_crc_frame_builder: FAILED **");
      end
      $finish;
   end

endmodule
